@@ hw/rtl/lz4c_pkg.sv @@
// Shared constants, word types and command codes of the LZ4 block compressor.
`timescale 1ns / 1ps
package lz4c_pkg;

   // Source block and match finder geometry
   localparam int MAX_INPUT  = 65536;
   localparam int SRC_AW     = $clog2(MAX_INPUT);
   localparam int POS_W      = SRC_AW + 1;
   localparam int HASH_BITS  = 14;
   localparam int MAX_OUTPUT = 131072;
   localparam int OUT_AW     = $clog2(MAX_OUTPUT);
   localparam int CNT_W      = OUT_AW + 1;
   localparam int CAP_W      = 18;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam int MIN_MATCH  = 4;
   localparam int END_GUARD  = 5;
   localparam int MAX_OFFSET = 65535;
   localparam int RUN_MASK   = 15;
   localparam int LEN_RUN    = 255;

   // Input word opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CAP      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   // Register index of out_capacity
   localparam logic CSR_OUT_CAPACITY = 1'b0;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             is_last;
      logic [1:0]       status;
      logic [CAP_W-1:0] comp_length;
   } rsp_word_type;

   // One datapath operation per cycle
   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_RSP_RD,
      CMD_RSP_BLK,
      CMD_INIT,
      CMD_CLEAR,
      CMD_TOP,
      CMD_HRD,
      CMD_MUL,
      CMD_TRD,
      CMD_TWR,
      CMD_CHK,
      CMD_CMP,
      CMD_MSTART,
      CMD_INC,
      CMD_EXT_RD,
      CMD_EXT_CK,
      CMD_SEQ,
      CMD_FIN,
      CMD_PUT_TOK,
      CMD_PUT_LEN,
      CMD_LIT_RD,
      CMD_PUT_LIT,
      CMD_PUT_OFFLO,
      CMD_PUT_OFFHI,
      CMD_ADV
   } cmd_type;

   typedef struct packed {
      logic will_ovf;
      logic clr_last;
      logic fail;
      logic ip_lt_limit;
      logic k_last;
      logic ref_ge_ip;
      logic off_big;
      logic eq;
      logic mp_lt_limit;
      logic q_eq;
      logic lit_ge15;
      logic ml_ge15;
      logic ext_ge255;
      logic lrem_zero;
      logic rsp_busy;
   } ctl_status_type;

endpackage

@@ hw/rtl/lz4c_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface lz4c_req_if;
   import lz4c_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lz4c_rsp_if;
   import lz4c_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/lz4c_csr.sv @@
// APB register block holding the output capacity.
`timescale 1ns / 1ps
module lz4c_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic [lz4c_pkg::CAP_W-1:0] out_capacity
);
   import lz4c_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             wr_hit;

   // Write on the access phase of a register hit
   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_OUT_CAPACITY);
   assign cap_in = wr_hit ? pwdata[CAP_W-1:0] : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(MAX_OUTPUT);
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Read back
   assign prdata       = (paddr[2] == CSR_OUT_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_ff} : 32'd0;
   assign pready       = 1'b1;
   assign out_capacity = cap_ff;
endmodule

@@ hw/rtl/lz4c_ctrl.sv @@
// Sequencer that steps the datapath through load, read and compression.
`timescale 1ns / 1ps
module lz4c_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   input  logic                    req_last,
   output logic                    req_ready,
   input  lz4c_pkg::ctl_status_type status,
   output lz4c_pkg::cmd_type        cmd
);
   import lz4c_pkg::*;

   typedef enum logic [25:0] {
      ST_IDLE    = 26'h0000001,
      ST_RD_OUT  = 26'h0000002,
      ST_BLK_RSP = 26'h0000004,
      ST_INIT    = 26'h0000008,
      ST_CLEAR   = 26'h0000010,
      ST_TOP     = 26'h0000020,
      ST_HASH    = 26'h0000040,
      ST_MUL     = 26'h0000080,
      ST_TRD     = 26'h0000100,
      ST_TWR     = 26'h0000200,
      ST_CHK     = 26'h0000400,
      ST_CMP     = 26'h0000800,
      ST_CMP_END = 26'h0001000,
      ST_INC     = 26'h0002000,
      ST_EXT_RD  = 26'h0004000,
      ST_EXT_CK  = 26'h0008000,
      ST_SEQ     = 26'h0010000,
      ST_FIN     = 26'h0020000,
      ST_TOK     = 26'h0040000,
      ST_LLEN    = 26'h0080000,
      ST_LIT_RD  = 26'h0100000,
      ST_LIT_WR  = 26'h0200000,
      ST_OFF_LO  = 26'h0400000,
      ST_OFF_HI  = 26'h0800000,
      ST_MLEN    = 26'h1000000,
      ST_ADV     = 26'h2000000
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && !status.rsp_busy;
   assign accept    = req_valid && req_ready;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd      = CMD_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_READ) begin
                  state_in = ST_RD_OUT;
               end else begin
                  cmd = CMD_LOAD;
                  if (req_last) begin
                     state_in = status.will_ovf ? ST_BLK_RSP : ST_INIT;
                  end
               end
            end
         end
         ST_RD_OUT: begin
            cmd      = CMD_RSP_RD;
            state_in = ST_IDLE;
         end
         ST_BLK_RSP: begin
            cmd      = CMD_RSP_BLK;
            state_in = ST_IDLE;
         end
         ST_INIT: begin
            cmd      = CMD_INIT;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clr_last) state_in = ST_TOP;
         end
         ST_TOP: begin
            if (status.fail) begin
               state_in = ST_BLK_RSP;
            end else if (!status.ip_lt_limit) begin
               state_in = ST_FIN;
            end else begin
               cmd      = CMD_TOP;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd = CMD_HRD;
            if (status.k_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd      = CMD_MUL;
            state_in = ST_TRD;
         end
         ST_TRD: begin
            cmd      = CMD_TRD;
            state_in = ST_TWR;
         end
         ST_TWR: begin
            cmd      = CMD_TWR;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd      = CMD_CHK;
            state_in = (status.ref_ge_ip || status.off_big) ? ST_INC : ST_CMP;
         end
         ST_CMP: begin
            cmd = CMD_CMP;
            if (status.k_last) state_in = ST_CMP_END;
         end
         ST_CMP_END: begin
            cmd      = CMD_MSTART;
            state_in = status.eq ? ST_EXT_RD : ST_INC;
         end
         ST_INC: begin
            cmd      = CMD_INC;
            state_in = ST_TOP;
         end
         ST_EXT_RD: begin
            if (status.mp_lt_limit) begin
               cmd      = CMD_EXT_RD;
               state_in = ST_EXT_CK;
            end else begin
               state_in = ST_SEQ;
            end
         end
         ST_EXT_CK: begin
            cmd      = CMD_EXT_CK;
            state_in = status.q_eq ? ST_EXT_RD : ST_SEQ;
         end
         ST_SEQ: begin
            cmd      = CMD_SEQ;
            fin_in   = 1'b0;
            state_in = ST_TOK;
         end
         ST_FIN: begin
            cmd      = CMD_FIN;
            fin_in   = 1'b1;
            state_in = ST_TOK;
         end
         ST_TOK: begin
            cmd      = CMD_PUT_TOK;
            state_in = status.lit_ge15 ? ST_LLEN : ST_LIT_RD;
         end
         ST_LLEN: begin
            if (status.fail) begin
               state_in = ST_BLK_RSP;
            end else begin
               cmd = CMD_PUT_LEN;
               if (!status.ext_ge255) state_in = ST_LIT_RD;
            end
         end
         ST_LIT_RD: begin
            if (status.fail) begin
               state_in = ST_BLK_RSP;
            end else if (status.lrem_zero) begin
               state_in = fin_ff ? ST_BLK_RSP : ST_OFF_LO;
            end else begin
               cmd      = CMD_LIT_RD;
               state_in = ST_LIT_WR;
            end
         end
         ST_LIT_WR: begin
            cmd      = CMD_PUT_LIT;
            state_in = ST_LIT_RD;
         end
         ST_OFF_LO: begin
            cmd      = CMD_PUT_OFFLO;
            state_in = ST_OFF_HI;
         end
         ST_OFF_HI: begin
            cmd      = CMD_PUT_OFFHI;
            state_in = status.ml_ge15 ? ST_MLEN : ST_ADV;
         end
         ST_MLEN: begin
            if (status.fail) begin
               state_in = ST_BLK_RSP;
            end else begin
               cmd = CMD_PUT_LEN;
               if (!status.ext_ge255) state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd      = CMD_ADV;
            state_in = ST_TOP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end
endmodule

@@ hw/rtl/lz4c_dpath.sv @@
// Datapath: source, hash and output memories, match finder registers, result word.
`timescale 1ns / 1ps
module lz4c_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  lz4c_pkg::cmd_type          cmd,
   input  logic [7:0]                 load_byte,
   input  logic [lz4c_pkg::CAP_W-1:0] out_capacity,
   output lz4c_pkg::ctl_status_type   status,
   lz4c_rsp_if.source                 rsp_chan
);
   import lz4c_pkg::*;

   // Memories and their registered read data
   logic [7:0]        src_mem [MAX_INPUT];
   logic [SRC_AW-1:0] ptab_mem [2**HASH_BITS];
   logic [7:0]        out_mem [MAX_OUTPUT];
   logic [7:0]        qa_ff, qb_ff, oq_ff;
   logic [SRC_AW-1:0] pq_ff;

   // Control state
   logic [POS_W-1:0] loaded_ff, loaded_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rp_ff, rp_in;
   logic             rdy_ff, rdy_in;
   logic             fail_ff, fail_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic [POS_W-1:0]     limit_ff, limit_in;
   logic [POS_W-1:0]     ip_ff, ip_in;
   logic [POS_W-1:0]     anchor_ff, anchor_in;
   logic [POS_W-1:0]     mp_ff, mp_in;
   logic [SRC_AW-1:0]    mref_ff, mref_in;
   logic [SRC_AW-1:0]    off_ff, off_in;
   logic [2:0]           k_ff, k_in;
   logic                 eq_ff, eq_in;
   logic [31:0]          v_ff, v_in;
   logic [HASH_BITS-1:0] h_ff, h_in;
   logic [HASH_BITS-1:0] clr_ff, clr_in;
   logic [POS_W-1:0]     lit_ff, lit_in;
   logic [POS_W-1:0]     ml_ff, ml_in;
   logic [POS_W-1:0]     ext_ff, ext_in;
   logic [POS_W-1:0]     lp_ff, lp_in;
   logic [POS_W-1:0]     lrem_ff, lrem_in;
   rsp_word_type         rsp_ff, rsp_in;

   // Combinational helpers
   logic [SRC_AW-1:0] addr_a, addr_b;
   logic [31:0]       prod;
   logic [POS_W-1:0]  off_full;
   logic [1:0]        kb;
   logic [7:0]        vbyte;
   logic              put_en;
   logic [7:0]        put_val;
   logic              put_ok;
   logic              src_we;
   logic              ptab_we;
   logic [SRC_AW-1:0] ptab_wd;
   logic [CNT_W-1:0]  blk_cc;
   logic              rd_ok;

   assign prod     = v_ff * HASH_MULT;
   assign off_full = ip_ff - {1'b0, mref_ff};
   assign kb       = k_ff[1:0] - 2'd1;
   assign vbyte    = v_ff[8*kb +: 8];
   assign blk_cc   = fail_ff ? '0 : cnt_ff;
   assign rd_ok    = rdy_ff && (rp_ff < cnt_ff);

   // Source read addresses
   always_comb begin
      case (cmd)
         CMD_HRD:    addr_a = SRC_AW'(ip_ff + POS_W'(k_ff));
         CMD_EXT_RD: addr_a = mp_ff[SRC_AW-1:0];
         CMD_LIT_RD: addr_a = lp_ff[SRC_AW-1:0];
         default:    addr_a = ip_ff[SRC_AW-1:0];
      endcase
      case (cmd)
         CMD_CMP:    addr_b = mref_ff + SRC_AW'(k_ff);
         CMD_EXT_RD: addr_b = SRC_AW'(mp_ff - POS_W'(off_ff));
         default:    addr_b = mref_ff;
      endcase
   end

   // Output byte selection
   always_comb begin
      put_en  = 1'b1;
      put_val = 8'd0;
      case (cmd)
         CMD_PUT_TOK: begin
            put_val[7:4] = (lit_ff >= POS_W'(RUN_MASK)) ? 4'hF : lit_ff[3:0];
            put_val[3:0] = (ml_ff >= POS_W'(RUN_MASK)) ? 4'hF : ml_ff[3:0];
         end
         CMD_PUT_LEN:   put_val = (ext_ff >= POS_W'(LEN_RUN)) ? 8'hFF : ext_ff[7:0];
         CMD_PUT_LIT:   put_val = qa_ff;
         CMD_PUT_OFFLO: put_val = off_ff[7:0];
         CMD_PUT_OFFHI: put_val = off_ff[15:8];
         default:       put_en  = 1'b0;
      endcase
   end

   assign put_ok  = put_en && !fail_ff && (CAP_W'(cnt_ff) < cap_ff);
   assign src_we  = (cmd == CMD_LOAD) && (loaded_ff != POS_W'(MAX_INPUT));
   assign ptab_we = (cmd == CMD_CLEAR) || (cmd == CMD_TWR);
   assign ptab_wd = (cmd == CMD_TWR) ? ip_ff[SRC_AW-1:0] : '0;

   // Next register values
   always_comb begin
      loaded_in    = loaded_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      rp_in        = rp_ff;
      rdy_in       = rdy_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      cap_in       = cap_ff;
      limit_in     = limit_ff;
      ip_in        = ip_ff;
      anchor_in    = anchor_ff;
      mp_in        = mp_ff;
      mref_in      = mref_ff;
      off_in       = off_ff;
      k_in         = k_ff;
      eq_in        = eq_ff;
      v_in         = v_ff;
      h_in         = h_ff;
      clr_in       = clr_ff;
      lit_in       = lit_ff;
      ml_in        = ml_ff;
      ext_in       = ext_ff;
      lp_in        = lp_ff;
      lrem_in      = lrem_ff;
      rsp_in       = rsp_ff;

      // Append a byte to the output, or fail on capacity
      if (put_en && !fail_ff) begin
         if (put_ok) cnt_in = cnt_ff + CNT_W'(1);
         else fail_in = 1'b1;
      end

      case (cmd)
         CMD_LOAD: begin
            if (src_we) loaded_in = loaded_ff + POS_W'(1);
            else ovf_in = 1'b1;
         end
         CMD_RSP_RD: begin
            rsp_valid_in = 1'b1;
            if (rd_ok) begin
               rsp_in.out_byte    = oq_ff;
               rsp_in.is_last     = (rp_ff + CNT_W'(1)) == cnt_ff;
               rsp_in.status      = STATUS_OK;
               rsp_in.comp_length = CAP_W'(cnt_ff);
               rp_in              = rp_ff + CNT_W'(1);
            end else begin
               rsp_in.out_byte    = 8'd0;
               rsp_in.is_last     = 1'b0;
               rsp_in.status      = STATUS_EMPTY;
               rsp_in.comp_length = '0;
            end
         end
         CMD_RSP_BLK: begin
            rsp_valid_in    = 1'b1;
            rsp_in.out_byte = 8'd0;
            rsp_in.is_last  = 1'b0;
            if (ovf_ff) begin
               rsp_in.status      = STATUS_OVERFLOW;
               rsp_in.comp_length = '0;
               cnt_in             = '0;
               rdy_in             = 1'b0;
            end else begin
               rsp_in.status      = (blk_cc != '0) ? STATUS_OK : STATUS_CAP;
               rsp_in.comp_length = CAP_W'(blk_cc);
               cnt_in             = blk_cc;
               rdy_in             = blk_cc != '0;
            end
            loaded_in = '0;
            ovf_in    = 1'b0;
            rp_in     = '0;
         end
         CMD_INIT: begin
            ip_in     = POS_W'(1);
            anchor_in = '0;
            cnt_in    = '0;
            fail_in   = 1'b0;
            clr_in    = '0;
            cap_in    = (out_capacity > CAP_W'(MAX_OUTPUT)) ? CAP_W'(MAX_OUTPUT) : out_capacity;
            limit_in  = (loaded_ff > POS_W'(END_GUARD)) ? loaded_ff - POS_W'(END_GUARD) : '0;
         end
         CMD_CLEAR: clr_in = clr_ff + HASH_BITS'(1);
         CMD_TOP:   k_in = '0;
         CMD_HRD: begin
            if (k_ff != 3'd0) v_in = {qa_ff, v_ff[31:8]};
            k_in = k_ff + 3'd1;
         end
         CMD_MUL: h_in = prod[31 -: HASH_BITS];
         CMD_TWR: mref_in = pq_ff;
         CMD_CHK: begin
            off_in = off_full[SRC_AW-1:0];
            k_in   = '0;
            eq_in  = 1'b1;
         end
         CMD_CMP: begin
            if (k_ff != 3'd0) eq_in = eq_ff && (qb_ff == vbyte);
            k_in = k_ff + 3'd1;
         end
         CMD_MSTART: mp_in = ip_ff + POS_W'(MIN_MATCH);
         CMD_INC:    ip_in = ip_ff + POS_W'(1);
         CMD_EXT_CK: begin
            if (qa_ff == qb_ff) mp_in = mp_ff + POS_W'(1);
         end
         CMD_SEQ: begin
            lit_in = ip_ff - anchor_ff;
            ml_in  = mp_ff - ip_ff - POS_W'(MIN_MATCH);
         end
         CMD_FIN: begin
            lit_in = loaded_ff - anchor_ff;
            ml_in  = '0;
         end
         CMD_PUT_TOK: begin
            ext_in  = lit_ff - POS_W'(RUN_MASK);
            lp_in   = anchor_ff;
            lrem_in = lit_ff;
         end
         CMD_PUT_LEN: begin
            if (ext_ff >= POS_W'(LEN_RUN)) ext_in = ext_ff - POS_W'(LEN_RUN);
         end
         CMD_PUT_LIT: begin
            lp_in   = lp_ff + POS_W'(1);
            lrem_in = lrem_ff - POS_W'(1);
         end
         CMD_PUT_OFFHI: ext_in = ml_ff - POS_W'(RUN_MASK);
         CMD_ADV: begin
            ip_in     = mp_ff;
            anchor_in = mp_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         rp_ff        <= '0;
         rdy_ff       <= 1'b0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         rp_ff        <= rp_in;
         rdy_ff       <= rdy_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cap_ff    <= cap_in;
      limit_ff  <= limit_in;
      ip_ff     <= ip_in;
      anchor_ff <= anchor_in;
      mp_ff     <= mp_in;
      mref_ff   <= mref_in;
      off_ff    <= off_in;
      k_ff      <= k_in;
      eq_ff     <= eq_in;
      v_ff      <= v_in;
      h_ff      <= h_in;
      clr_ff    <= clr_in;
      lit_ff    <= lit_in;
      ml_ff     <= ml_in;
      ext_ff    <= ext_in;
      lp_ff     <= lp_in;
      lrem_ff   <= lrem_in;
      rsp_ff    <= rsp_in;
   end

   // Source store: one write port, two read ports
   always_ff @(posedge clock) begin
      if (src_we) src_mem[loaded_ff[SRC_AW-1:0]] <= load_byte;
      qa_ff <= src_mem[addr_a];
      qb_ff <= src_mem[addr_b];
   end

   // Position table: clear sweep and update at the hash slot
   always_ff @(posedge clock) begin
      if (ptab_we) ptab_mem[(cmd == CMD_CLEAR) ? clr_ff : h_ff] <= ptab_wd;
      pq_ff <= ptab_mem[h_ff];
   end

   // Output store: append at count, read at the read pointer
   always_ff @(posedge clock) begin
      if (put_ok) out_mem[cnt_ff[OUT_AW-1:0]] <= put_val;
      oq_ff <= out_mem[rp_ff[OUT_AW-1:0]];
   end

   // Status to the sequencer
   always_comb begin
      status.will_ovf    = ovf_ff || (loaded_ff == POS_W'(MAX_INPUT));
      status.clr_last    = &clr_ff;
      status.fail        = fail_ff;
      status.ip_lt_limit = ip_ff < limit_ff;
      status.k_last      = k_ff == 3'd4;
      status.ref_ge_ip   = {1'b0, mref_ff} >= ip_ff;
      status.off_big     = off_full > POS_W'(MAX_OFFSET);
      status.eq          = eq_ff;
      status.mp_lt_limit = mp_ff < limit_ff;
      status.q_eq        = qa_ff == qb_ff;
      status.lit_ge15    = lit_ff >= POS_W'(RUN_MASK);
      status.ml_ge15     = ml_ff >= POS_W'(RUN_MASK);
      status.ext_ge255   = ext_ff >= POS_W'(LEN_RUN);
      status.lrem_zero   = lrem_ff == '0;
      status.rsp_busy    = rsp_valid_ff && !rsp_chan.ready;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule

@@ hw/rtl/lz4_block_compressor.sv @@
// Top level of the LZ4 block compressor: register block, sequencer and datapath.
// Load words are taken one per cycle while the result channel is not stalled; a read word's
// result passes the RD_OUT state and the result register, and no word is taken while in RD_OUT.
// Unless the input overflowed, a load carrying last_byte first sweeps the 16384-entry position
// table, then the sequencer walks the block: it hashes, looks up and updates each position,
// compares four bytes at a candidate, extends matches, writes literals, then issues the result.
// Reset is synchronous, active high: counters, flags and the result valid clear on a clock edge.
`timescale 1ns / 1ps
module lz4_block_compressor (
   input  logic        clock,
   input  logic        reset,
   lz4c_req_if.sink    req_chan,
   lz4c_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lz4c_pkg::*;

   logic [CAP_W-1:0] out_capacity;
   ctl_status_type   status;
   cmd_type          cmd;

   lz4c_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .out_capacity (out_capacity)
   );

   lz4c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.payload.op),
      .req_last  (req_chan.payload.last_byte),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lz4c_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .load_byte    (req_chan.payload.data_byte),
      .out_capacity (out_capacity),
      .status       (status),
      .rsp_chan     (rsp_chan)
   );
endmodule

@@ hw/rtl/lz4c_chk.sv @@
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module lz4c_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lz4c_pkg::rsp_word_type rsp_payload
);
   import lz4c_pkg::*;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word dropped or changed while stalled");

   // A successful result always carries a nonzero length
   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_OK) |-> rsp_payload.comp_length != '0)
      else $error("ok result with zero length");

   // Failures carry no length and no byte
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_OK) |->
         (rsp_payload.comp_length == '0) && (rsp_payload.out_byte == 8'd0) &&
         !rsp_payload.is_last)
      else $error("failed result carries data");

   // The final-byte flag only appears on good results
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_last |-> rsp_payload.status == STATUS_OK)
      else $error("last flag on a failed result");
endmodule

bind lz4_block_compressor lz4c_chk u_lz4c_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

@@ sim/lz4c_tb_checker.sv @@
// Scoreboard of the LZ4 block compressor: watches both channels and the register port.
`timescale 1ns / 1ps
module lz4c_tb_checker (
   input  logic        clock,
   input  logic        reset,
   lz4c_req_if         req_mon,
   lz4c_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          words_pending,
   output int          readable_len
);
   import lz4c_pkg::*;

   // Shadow copy of the block's state
   logic [7:0]       src_mem [MAX_INPUT];
   logic [15:0]      pos_tab [1 << HASH_BITS];
   logic [7:0]       out_mem [MAX_OUTPUT];
   logic [CAP_W-1:0] capacity;
   int               loaded;
   int               packed_len;
   int               rd_ptr;
   bit               in_ovf;
   bit               out_valid;
   int               pack_cap;
   bit               pack_fail;

   rsp_word_type     expected_words [$];

   assign words_pending = expected_words.size();
   assign readable_len  = out_valid ? packed_len : 0;

   // Append one compressed byte unless the capacity is spent
   function void emit_byte(input int b);
      if (pack_fail) return;
      if (packed_len >= pack_cap) begin
         pack_fail = 1'b1;
         return;
      end
      out_mem[packed_len] = b[7:0];
      packed_len++;
   endfunction

   function void emit_len(input int n);
      int rem;
      rem = n;
      while (rem >= LEN_RUN && !pack_fail) begin
         emit_byte(LEN_RUN);
         rem -= LEN_RUN;
      end
      emit_byte(rem);
   endfunction

   function void emit_literals(input int from, input int count);
      for (int i = 0; i < count && !pack_fail; i++) emit_byte(src_mem[from + i]);
   endfunction

   function int hash_at(input int p);
      logic [31:0] word;
      logic [31:0] prod;
      word = {src_mem[p + 3], src_mem[p + 2], src_mem[p + 1], src_mem[p]};
      prod = word * HASH_MULT;
      return int'(prod >> (32 - HASH_BITS));
   endfunction

   // Greedy single-probe LZ4 packing of the loaded block
   function void pack_block(input int size);
      int ip, anchor, lim, lit, tok, h, ref_pos, off, mlen, mp, ml;
      ip = 1;
      anchor = 0;
      lim = (size > END_GUARD) ? size - END_GUARD : 0;
      for (int i = 0; i < (1 << HASH_BITS); i++) pos_tab[i] = '0;
      packed_len = 0;
      pack_fail = 1'b0;
      pack_cap = (capacity > MAX_OUTPUT) ? MAX_OUTPUT : int'(capacity);
      while (ip < lim && !pack_fail) begin
         h = hash_at(ip);
         ref_pos = pos_tab[h];
         pos_tab[h] = ip[15:0];
         if (ref_pos >= ip) begin
            ip++;
            continue;
         end
         off = ip - ref_pos;
         if (off > MAX_OFFSET || src_mem[ip] != src_mem[ref_pos] ||
             src_mem[ip + 1] != src_mem[ref_pos + 1] ||
             src_mem[ip + 2] != src_mem[ref_pos + 2] ||
             src_mem[ip + 3] != src_mem[ref_pos + 3]) begin
            ip++;
            continue;
         end
         mlen = MIN_MATCH;
         mp = ip + MIN_MATCH;
         while (mp < lim && src_mem[mp] == src_mem[mp - off]) begin
            mp++;
            mlen++;
         end
         lit = ip - anchor;
         ml = mlen - MIN_MATCH;
         tok = ((lit >= RUN_MASK) ? 'hF0 : (lit << 4)) | ((ml >= RUN_MASK) ? RUN_MASK : ml);
         emit_byte(tok);
         if (lit >= RUN_MASK) emit_len(lit - RUN_MASK);
         emit_literals(anchor, lit);
         emit_byte(off & 'hFF);
         emit_byte((off >> 8) & 'hFF);
         if (ml >= RUN_MASK) emit_len(ml - RUN_MASK);
         ip += mlen;
         anchor = ip;
      end
      lit = size - anchor;
      emit_byte((lit >= RUN_MASK) ? 'hF0 : (lit << 4));
      if (lit >= RUN_MASK) emit_len(lit - RUN_MASK);
      emit_literals(anchor, lit);
      if (pack_fail) packed_len = 0;
   endfunction

   // Advance the shadow state by one accepted word
   function void take_word(input req_word_type w);
      rsp_word_type e;
      e = '0;
      if (w.op == OP_READ) begin
         if (out_valid && rd_ptr < packed_len) begin
            e.out_byte    = out_mem[rd_ptr];
            e.is_last     = (rd_ptr + 1 == packed_len);
            e.status      = STATUS_OK;
            e.comp_length = packed_len[CAP_W-1:0];
            rd_ptr++;
         end else begin
            e.status = STATUS_EMPTY;
         end
         expected_words.push_back(e);
         return;
      end
      if (loaded < MAX_INPUT) begin
         src_mem[loaded] = w.data_byte;
         loaded++;
      end else begin
         in_ovf = 1'b1;
      end
      if (!w.last_byte) return;
      if (in_ovf) begin
         packed_len = 0;
         out_valid = 1'b0;
         e.status = STATUS_OVERFLOW;
      end else begin
         pack_block(loaded);
         out_valid = (packed_len != 0);
         e.status = out_valid ? STATUS_OK : STATUS_CAP;
         e.comp_length = packed_len[CAP_W-1:0];
      end
      loaded = 0;
      in_ovf = 1'b0;
      rd_ptr = 0;
      expected_words.push_back(e);
   endfunction

   // Hold each returned word against the oldest prediction
   function void check_word(input rsp_word_type got);
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         $error("unexpected result word %h", got);
         fail_count++;
         return;
      end
      want = expected_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte expected %0d actual %0d", want.out_byte, got.out_byte);
         fail_count++;
      end
      if (got.is_last !== want.is_last) begin
         $error("is_last expected %0d actual %0d", want.is_last, got.is_last);
         fail_count++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         fail_count++;
      end
      if (got.comp_length !== want.comp_length) begin
         $error("comp_length expected %0d actual %0d", want.comp_length, got.comp_length);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         capacity = CAP_W'(MAX_OUTPUT);
         loaded = 0;
         packed_len = 0;
         rd_ptr = 0;
         in_ovf = 1'b0;
         out_valid = 1'b0;
         expected_words.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr[2] == CSR_OUT_CAPACITY && paddr[1:0] == 2'b00)
            capacity = pwdata[CAP_W-1:0];
         if (req_mon.valid && req_mon.ready) take_word(req_mon.payload);
         if (rsp_mon.valid && rsp_mon.ready) check_word(rsp_mon.payload);
      end
   end

endmodule

@@ sim/tb_lz4_block_compressor.sv @@
// Testbench top of the LZ4 block compressor: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_lz4_block_compressor;
   import lz4c_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          words_pending;
   int          readable_len;
   bit          quiet;
   int          idle_cycles;
   int          items_sent;

   lz4c_req_if req_chan ();
   lz4c_rsp_if rsp_chan ();

   lz4_block_compressor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   lz4c_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .readable_len  (readable_len)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Accept result words with random stalls
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Offer one word, after a random gap, and hold it until taken
   task automatic send_word(input logic op, input logic [7:0] data, input logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= '{op: op, data_byte: data, last_byte: last};
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_OUT_CAPACITY, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Load a block from a byte list, marking the final byte
   task automatic load_block(input logic [7:0] bytes [$]);
      foreach (bytes[i]) send_word(OP_LOAD, bytes[i], i == bytes.size() - 1);
   endtask

   // Read the stored output plus a few words past its end
   task automatic read_out(input int extra);
      int n;
      drain();
      n = readable_len + extra;
      for (int i = 0; i < n; i++) send_word(OP_READ, 8'($urandom), 1'($urandom));
   endtask

   // Block contents: random, small alphabet, or a repeated pattern
   task automatic make_block(input int size, output logic [7:0] bytes [$]);
      int kind, plen;
      logic [7:0] pat [8];
      kind = $urandom_range(0, 2);
      plen = $urandom_range(1, 8);
      foreach (pat[i]) pat[i] = 8'($urandom);
      bytes.delete();
      for (int i = 0; i < size; i++) begin
         case (kind)
            0: bytes.push_back(8'($urandom));
            1: bytes.push_back(8'h41 + 8'($urandom_range(0, 2)));
            default: bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : pat[i % plen]);
         endcase
      end
   endtask

   initial begin
      logic [7:0] blk [$];
      logic [CAP_W-1:0] cap_pick;
      items_sent     = 0;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      quiet   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reads with nothing stored, then the shortest blocks
      send_word(OP_READ, 8'hFF, 1'b1);
      send_word(OP_READ, 8'h00, 1'b0);
      load_block('{8'hFF});
      read_out(1);
      load_block('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
      read_out(1);
      load_block('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h61,
                   8'h62, 8'h63, 8'h61, 8'h62});
      read_out(0);

      // Literal run with one extension byte, long match past a 255 extension byte
      make_block(30, blk);
      foreach (blk[i]) blk[i] = 8'($urandom);
      load_block(blk);
      read_out(1);
      blk.delete();
      repeat (280) blk.push_back(8'h00);
      load_block(blk);
      read_out(1);

      // Capacity extremes: none, one byte, beyond the store
      drain();
      write_capacity('0);
      load_block('{8'h12, 8'h34});
      read_out(1);
      drain();
      write_capacity(CAP_W'(1));
      load_block('{8'h12});
      read_out(1);
      drain();
      write_capacity('1);
      load_block('{8'h5A, 8'hA5, 8'h5A});
      read_out(0);

      // Random blocks under changing capacity
      while (items_sent < 450) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            case ($urandom_range(0, 4))
               0: cap_pick = '0;
               1: cap_pick = CAP_W'(MAX_OUTPUT);
               2: cap_pick = '1;
               default: cap_pick = CAP_W'($urandom_range(1, 40));
            endcase
            write_capacity(cap_pick);
         end
         quiet = ($urandom_range(0, 3) == 0);
         make_block(($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                : $urandom_range(1, 24), blk);
         load_block(blk);
         if ($urandom_range(0, 5) == 0) begin
            // Start the next block without reading this one out
            send_word(OP_READ, 8'($urandom), 1'($urandom));
         end else begin
            read_out($urandom_range(0, 2));
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
